/* src/taq_pkg.sv */
// Types and codes shared by the timed arrival event queue modules.
// No dependencies.
package taq_pkg;

    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_ADVANCE  = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EARLY   = 3'd1;
    localparam logic [2:0] ST_SAMEID  = 3'd2;
    localparam logic [2:0] ST_ZEROAMP = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_BACK    = 3'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [46:0]        tick;
        logic [15:0]        src_id;
        logic [15:0]        dst_id;
        logic signed [15:0] amplitude;
        logic [16:0]        distance;
        logic [47:0]        arrival;
        logic [30:0]        energy;
        logic               same_ids;
        logic               zero_amp;
    } t_cmd;

    typedef struct packed {
        logic [47:0]        arrival;
        logic [46:0]        emission;
        logic [31:0]        sequence_tag;
        logic [15:0]        src_id;
        logic [15:0]        dst_id;
        logic signed [15:0] amplitude;
        logic [16:0]        distance;
        logic [30:0]        energy;
    } t_entry;

    typedef struct packed {
        logic [2:0]         status;
        logic               has_carrier;
        logic               last_result;
        logic [31:0]        sequence_res;
        logic [46:0]        emit_tick;
        logic [47:0]        arr_tick;
        logic [16:0]        distance;
        logic [15:0]        carrier_source;
        logic [15:0]        carrier_target;
        logic signed [15:0] carrier_amplitude;
        logic [30:0]        energy;
        logic [34:0]        in_flight_energy;
    } t_res;

endpackage

/* src/taq_front.sv */
// Front part: accepts input items, works out distance, arrival and energy.
// Depends on taq_pkg.
module taq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_kind,
    input  logic [46:0]         i_tick,
    input  logic [15:0]         i_source_id,
    input  logic [15:0]         i_target_id,
    input  logic signed [31:0]  i_src_x,
    input  logic signed [31:0]  i_src_y,
    input  logic signed [31:0]  i_src_z,
    input  logic signed [31:0]  i_dst_x,
    input  logic signed [31:0]  i_dst_y,
    input  logic signed [31:0]  i_dst_z,
    input  logic signed [15:0]  i_amplitude,
    output logic                o_cmd_push,
    output taq_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_full
);
    import taq_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_GAP, F_DIST, F_PUSH} t_fstate;

    t_fstate            r_state;
    logic signed [31:0] r_src [3];
    logic signed [31:0] r_dst [3];
    logic [31:0]        r_gap [3];
    t_cmd               r_cmd;

    logic [32:0]        w_diff [3];
    logic [31:0]        w_abs  [3];
    logic [31:0]        w_max;
    logic [32:0]        w_ceil;
    logic [16:0]        w_dist;
    logic signed [31:0] w_sq;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = {r_dst[k][31], r_dst[k]} - {r_src[k][31], r_src[k]};
            w_abs[k]  = w_diff[k][32] ? 32'(-w_diff[k]) : w_diff[k][31:0];
        end
        w_max = (r_gap[0] > r_gap[1]) ? r_gap[0] : r_gap[1];
        if (r_gap[2] > w_max) begin
            w_max = r_gap[2];
        end
        w_ceil = {1'b0, w_max} + 33'd65535;
        w_dist = (w_ceil[32:16] == 17'd0) ? 17'd1 : w_ceil[32:16];
        w_sq   = r_cmd.amplitude * r_cmd.amplitude;
    end

    assign o_full     = (r_state != F_IDLE);
    assign o_cmd_push = (r_state == F_PUSH) && !i_cmd_full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_cmd.kind      <= i_kind;
                        r_cmd.tick      <= i_tick;
                        r_cmd.src_id    <= i_source_id;
                        r_cmd.dst_id    <= i_target_id;
                        r_cmd.amplitude <= i_amplitude;
                        r_cmd.same_ids  <= (i_source_id == i_target_id);
                        r_cmd.zero_amp  <= (i_amplitude == 16'sd0);
                        r_src[0] <= i_src_x;
                        r_src[1] <= i_src_y;
                        r_src[2] <= i_src_z;
                        r_dst[0] <= i_dst_x;
                        r_dst[1] <= i_dst_y;
                        r_dst[2] <= i_dst_z;
                        r_state  <= F_GAP;
                    end
                end
                F_GAP: begin
                    for (int k = 0; k < 3; k++) begin
                        r_gap[k] <= w_abs[k];
                    end
                    r_cmd.energy <= w_sq[30:0];
                    r_state      <= F_DIST;
                end
                F_DIST: begin
                    r_cmd.distance <= w_dist;
                    r_cmd.arrival  <= {1'b0, r_cmd.tick} + {31'd0, w_dist};
                    r_state        <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_cmd_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

/* src/taq_fifo.sv */
// Two-entry command queue between the front and back parts.
// Depends on taq_pkg.
module taq_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  taq_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output taq_pkg::t_cmd o_data,
    output logic          o_empty
);
    import taq_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

endmodule

/* src/taq_back.sv */
// Back part: sorted carrier queue, tick state and result register.
// Depends on taq_pkg.
module taq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  taq_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output taq_pkg::t_res o_res,
    output logic          o_empty,
    input  logic          i_pop
);
    import taq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {B_IDLE, B_EXEC, B_DRAIN} t_bstate;

    t_bstate     r_state;
    t_cmd        r_cmd;
    t_entry      r_q [QUEUE_DEPTH];
    logic [CW-1:0] r_count;
    logic [46:0] r_now;
    logic [31:0] r_tag;
    logic [34:0] r_pending;
    t_res        r_res;
    logic        r_valid;

    logic        w_slot;
    logic        w_le [QUEUE_DEPTH];
    t_entry      w_ins [QUEUE_DEPTH];
    t_entry      w_new;
    logic        w_head_due;
    logic        w_second_due;
    logic [2:0]  w_fail;
    t_res        w_plain;
    t_res        w_carrier;
    t_res        w_exec_res;
    logic        w_exec_go;

    assign w_slot    = !r_valid || i_pop;
    assign o_empty   = !r_valid;
    assign o_res     = r_res;
    assign o_cmd_pop = (r_state == B_IDLE) && !i_cmd_empty;

    always_comb begin
        w_new.arrival      = r_cmd.arrival;
        w_new.emission     = r_cmd.tick;
        w_new.sequence_tag = r_tag;
        w_new.src_id       = r_cmd.src_id;
        w_new.dst_id       = r_cmd.dst_id;
        w_new.amplitude    = r_cmd.amplitude;
        w_new.distance     = r_cmd.distance;
        w_new.energy       = r_cmd.energy;
        // keep entries at or before the new arrival, shift the rest up one
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_le[k] = (CW'(k) < r_count) && (r_q[k].arrival <= r_cmd.arrival);
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (w_le[k]) begin
                w_ins[k] = r_q[k];
            end else if (k == 0) begin
                w_ins[k] = w_new;
            end else if (w_le[(k > 0) ? k - 1 : 0]) begin
                w_ins[k] = w_new;
            end else begin
                w_ins[k] = r_q[(k > 0) ? k - 1 : 0];
            end
        end
        w_head_due = (r_count != '0) && (r_q[0].arrival <= {1'b0, r_now});
        w_second_due = 1'b0;
        if (QUEUE_DEPTH > 1) begin
            w_second_due = (r_count > CW'(1)) &&
                           (r_q[(QUEUE_DEPTH > 1) ? 1 : 0].arrival <= {1'b0, r_now});
        end
        priority if (r_cmd.tick < r_now) begin
            w_fail = ST_EARLY;
        end else if (r_cmd.same_ids) begin
            w_fail = ST_SAMEID;
        end else if (r_cmd.zero_amp) begin
            w_fail = ST_ZEROAMP;
        end else if (r_count >= CW'(QUEUE_DEPTH)) begin
            w_fail = ST_FULL;
        end else begin
            w_fail = ST_OK;
        end
        w_plain                  = '0;
        w_plain.last_result      = 1'b1;
        w_plain.in_flight_energy = r_pending;
        w_carrier                   = '0;
        w_carrier.sequence_res      = r_q[0].sequence_tag;
        w_carrier.emit_tick         = r_q[0].emission;
        w_carrier.arr_tick          = r_q[0].arrival;
        w_carrier.distance          = r_q[0].distance;
        w_carrier.carrier_source    = r_q[0].src_id;
        w_carrier.carrier_target    = r_q[0].dst_id;
        w_carrier.carrier_amplitude = r_q[0].amplitude;
        w_carrier.energy            = r_q[0].energy;
        w_carrier.has_carrier       = 1'b1;
        w_carrier.last_result       = !w_second_due;
        w_carrier.in_flight_energy  = r_pending - {4'd0, r_q[0].energy};
        // result of the execute step; an advance forward holds it for the drain
        w_exec_res = w_plain;
        w_exec_go  = 1'b1;
        unique case (r_cmd.kind)
            KIND_DISPATCH: begin
                if (w_fail != ST_OK) begin
                    w_exec_res.status = w_fail;
                end else begin
                    w_exec_res.sequence_res      = r_tag;
                    w_exec_res.emit_tick         = r_cmd.tick;
                    w_exec_res.arr_tick          = r_cmd.arrival;
                    w_exec_res.distance          = r_cmd.distance;
                    w_exec_res.carrier_source    = r_cmd.src_id;
                    w_exec_res.carrier_target    = r_cmd.dst_id;
                    w_exec_res.carrier_amplitude = r_cmd.amplitude;
                    w_exec_res.energy            = r_cmd.energy;
                    w_exec_res.in_flight_energy  = r_pending + {4'd0, r_cmd.energy};
                end
            end
            KIND_ADVANCE: begin
                if (r_cmd.tick < r_now) begin
                    w_exec_res.status = ST_BACK;
                end else begin
                    w_exec_go = 1'b0;
                end
            end
            KIND_CLEAR: begin
                w_exec_res.in_flight_energy = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_count   <= '0;
            r_now     <= '0;
            r_tag     <= '0;
            r_pending <= '0;
            r_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_pop && r_valid) begin
                        r_valid <= 1'b0;
                    end
                    if (!i_cmd_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    if (w_slot) begin
                        r_valid <= w_exec_go;
                        r_res   <= w_exec_res;
                        r_state <= w_exec_go ? B_IDLE : B_DRAIN;
                        unique case (r_cmd.kind)
                            KIND_DISPATCH: begin
                                if (w_fail == ST_OK) begin
                                    for (int k = 0; k < QUEUE_DEPTH; k++) begin
                                        r_q[k] <= w_ins[k];
                                    end
                                    r_count   <= r_count + CW'(1);
                                    r_tag     <= r_tag + 32'd1;
                                    r_pending <= r_pending + {4'd0, r_cmd.energy};
                                end
                            end
                            KIND_ADVANCE: begin
                                if (!(r_cmd.tick < r_now)) begin
                                    r_now <= r_cmd.tick;
                                end
                            end
                            KIND_CLEAR: begin
                                r_count   <= '0;
                                r_now     <= '0;
                                r_tag     <= '0;
                                r_pending <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                B_DRAIN: begin
                    if (w_slot) begin
                        r_valid <= 1'b1;
                        if (w_head_due) begin
                            r_res <= w_carrier;
                            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                                r_q[k] <= r_q[k + 1];
                            end
                            r_count   <= r_count - CW'(1);
                            r_pending <= w_carrier.in_flight_energy;
                            r_state   <= w_second_due ? B_DRAIN : B_IDLE;
                        end else begin
                            r_res   <= w_plain;
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

/* src/timed_arrival_event_queue_top.sv */
// Timed arrival event queue: an item passes through the front part
// (capture, axis gaps and energy multiply, distance, hand-over), then the
// back part takes it in and executes a dispatch, advance or clear; a
// dispatch inserts into the sorted queue with all entries compared in
// parallel. An advance then delivers one due carrier per cycle from the
// queue head while the output register is free. The front accepts one
// item at a time; a two-entry command queue lets it take the next item while
// the back part still works. Results wait in a one-entry output register. Queue depth is QUEUE_DEPTH.
// Top level; depends on taq_pkg, taq_front, taq_fifo and taq_back.
module timed_arrival_event_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_kind,
    input  logic [46:0]        i_tick,
    input  logic [15:0]        i_source_id,
    input  logic [15:0]        i_target_id,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_src_z,
    input  logic signed [31:0] i_dst_x,
    input  logic signed [31:0] i_dst_y,
    input  logic signed [31:0] i_dst_z,
    input  logic signed [15:0] i_amplitude,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_status,
    output logic               o_has_carrier,
    output logic               o_last_result,
    output logic [31:0]        o_sequence_res,
    output logic [46:0]        o_emission_tick,
    output logic [47:0]        o_arrival_tick,
    output logic [16:0]        o_distance,
    output logic [15:0]        o_carrier_source,
    output logic [15:0]        o_carrier_target,
    output logic signed [15:0] o_carrier_amplitude,
    output logic [30:0]        o_energy,
    output logic [34:0]        o_in_flight_energy
);
    import taq_pkg::*;

    logic f_push;
    logic f_full;
    logic f_pop;
    logic f_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;
    t_res w_res;

    taq_front u_front (
        .i_clk, .i_rst_n,
        .i_push      (push),
        .o_full      (full),
        .i_kind, .i_tick, .i_source_id, .i_target_id,
        .i_src_x, .i_src_y, .i_src_z, .i_dst_x, .i_dst_y, .i_dst_z,
        .i_amplitude,
        .o_cmd_push  (f_push),
        .o_cmd       (w_cmd_in),
        .i_cmd_full  (f_full)
    );

    taq_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push  (f_push),
        .i_data  (w_cmd_in),
        .o_full  (f_full),
        .i_pop   (f_pop),
        .o_data  (w_cmd_out),
        .o_empty (f_empty)
    );

    taq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_empty (f_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (f_pop),
        .o_res       (w_res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_status            = w_res.status;
    assign o_has_carrier       = w_res.has_carrier;
    assign o_last_result       = w_res.last_result;
    assign o_sequence_res      = w_res.sequence_res;
    assign o_emission_tick     = w_res.emit_tick;
    assign o_arrival_tick      = w_res.arr_tick;
    assign o_distance          = w_res.distance;
    assign o_carrier_source    = w_res.carrier_source;
    assign o_carrier_target    = w_res.carrier_target;
    assign o_carrier_amplitude = w_res.carrier_amplitude;
    assign o_energy            = w_res.energy;
    assign o_in_flight_energy  = w_res.in_flight_energy;

endmodule

/* src/taq_checker.sv */
// Port-level checks for the timed arrival event queue, bound to the top.
// Depends on taq_pkg and timed_arrival_event_queue_top.
module taq_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_status,
    input logic        o_has_carrier,
    input logic        o_last_result,
    input logic [31:0] o_sequence_res
);
    import taq_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_carrier_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_has_carrier) |-> (o_status == ST_OK))
        else $error("delivered carrier with error status");

    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_carrier) |-> o_last_result)
        else $error("plain result not marked last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sequence_res)))
        else $error("stalled result changed");

endmodule

bind timed_arrival_event_queue_top taq_port_checks u_taq_checker (
    .i_clk, .i_rst_n, .empty, .pop, .o_status, .o_has_carrier,
    .o_last_result, .o_sequence_res
);
